FILE: rtl/interleaved_mono_framebuffer_draw_defines.svh
// assertion macros shared by the rtl files
`ifndef INTERLEAVED_MONO_FRAMEBUFFER_DRAW_DEFINES_SVH
`define INTERLEAVED_MONO_FRAMEBUFFER_DRAW_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define IMFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IMFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/imfd_pkg.sv
`timescale 1ns / 1ps
package imfd_pkg;

	localparam int MODE_W = 3;
	localparam int X_W    = 10;
	localparam int Y_W    = 9;

	localparam int BYTES_PER_ROW = 90;
	localparam int BANK_BYTES    = 8192;
	localparam int SCREEN_WIDTH  = 720;
	localparam int SCREEN_HEIGHT = 350;

	localparam int STORE_DEPTH = 4 * BANK_BYTES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int BYTE_W      = X_W - 3;

	localparam logic [X_W-1:0] X_MAX = X_W'(SCREEN_WIDTH - 1);
	localparam logic [Y_W-1:0] Y_MAX = Y_W'(SCREEN_HEIGHT - 1);

	// row base steps: next row in the following bank, or back to bank 0 one line down
	localparam logic [ADDR_W-1:0] BANK_STEP = ADDR_W'(BANK_BYTES);
	localparam logic [ADDR_W-1:0] WRAP_STEP = ADDR_W'(BYTES_PER_ROW - 3 * BANK_BYTES);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_PIXEL = 3'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HSPAN = 3'd2;
	localparam logic [MODE_W-1:0] MODE_VSPAN = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RECT  = 3'd4;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_DRAW,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              colour;
		logic [BYTE_W-1:0] b_first;
		logic [BYTE_W-1:0] b_last;
		logic [7:0]        m_first;
		logic [7:0]        m_last;
		logic [Y_W-1:0]    y_first;
		logic [Y_W-1:0]    y_last;
		logic [ADDR_W-1:0] row_base;
	} cmd_t;

	function automatic logic [ADDR_W-1:0] row_base_of(input logic [Y_W-1:0] y);
		logic [ADDR_W-1:0] bank_part;
		logic [ADDR_W-1:0] line_part;
		bank_part = ADDR_W'(BANK_BYTES * int'(y[1:0]));
		line_part = ADDR_W'(BYTES_PER_ROW * int'(y[Y_W-1:2]));
		return bank_part + line_part;
	endfunction

endpackage

FILE: rtl/imfd_if.sv
`timescale 1ns / 1ps
interface imfd_req_if;
	import imfd_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [X_W-1:0]    x_start;
	logic [X_W-1:0]    x_end;
	logic [Y_W-1:0]    y_start;
	logic [Y_W-1:0]    y_end;
	logic              colour;

	modport source (output valid, output mode, output x_start, output x_end,
		output y_start, output y_end, output colour, input ready);
	modport sink (input valid, input mode, input x_start, input x_end,
		input y_start, input y_end, input colour, output ready);
endinterface

interface imfd_rsp_if;
	logic valid;
	logic ready;
	logic pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

FILE: rtl/imfd_front.sv
`timescale 1ns / 1ps
module imfd_front (
	imfd_req_if.sink       req,
	input  logic           full,
	input  logic           clearing,
	output logic           push,
	output imfd_pkg::cmd_t cmd
);
	import imfd_pkg::*;

	logic [X_W-1:0] x2c;
	logic [Y_W-1:0] y2c;
	logic           x_on;
	logic           y_on;
	logic           x_order;
	logic           y_order;
	logic [7:0]     m_left;
	logic [7:0]     m_right;
	logic [7:0]     m_pix;

	assign req.ready = !full && !clearing;
	assign push      = req.valid && req.ready;

	always_comb begin
		x2c     = (req.x_end > X_MAX) ? X_MAX : req.x_end;
		y2c     = (req.y_end > Y_MAX) ? Y_MAX : req.y_end;
		x_on    = req.x_start <= X_MAX;
		y_on    = req.y_start <= Y_MAX;
		// column order is judged on the unclipped end column, row order on the clipped end row
		x_order = req.x_start <= req.x_end;
		y_order = req.y_start <= y2c;
		m_left  = 8'hff >> req.x_start[2:0];
		m_right = 8'hff << (3'd7 - x2c[2:0]);
		m_pix   = 8'h80 >> req.x_start[2:0];

		cmd          = '0;
		cmd.op       = OP_NOP;
		cmd.colour   = req.colour;
		cmd.b_first  = req.x_start[X_W-1:3];
		cmd.b_last   = req.x_start[X_W-1:3];
		cmd.m_first  = m_pix;
		cmd.m_last   = m_pix;
		cmd.y_first  = req.y_start;
		cmd.y_last   = req.y_start;
		cmd.row_base = row_base_of(req.y_start);

		unique case (req.mode)
			MODE_PIXEL: begin
				if (x_on && y_on) cmd.op = OP_DRAW;
			end
			MODE_READ: begin
				if (x_on && y_on) cmd.op = OP_READ;
			end
			MODE_HSPAN: begin
				if (x_on && y_on && x_order) cmd.op = OP_DRAW;
				cmd.b_last  = x2c[X_W-1:3];
				cmd.m_first = m_left;
				cmd.m_last  = m_right;
			end
			MODE_VSPAN: begin
				if (x_on && y_order) cmd.op = OP_DRAW;
				cmd.y_last = y2c;
			end
			MODE_RECT: begin
				if (x_on && x_order && y_order) cmd.op = OP_DRAW;
				cmd.b_last  = x2c[X_W-1:3];
				cmd.m_first = m_left;
				cmd.m_last  = m_right;
				cmd.y_last  = y2c;
			end
			default: begin
				cmd.op = OP_NOP;
			end
		endcase
	end
endmodule

FILE: rtl/imfd_queue.sv
`timescale 1ns / 1ps
`include "interleaved_mono_framebuffer_draw_defines.svh"
module imfd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  imfd_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output imfd_pkg::cmd_t head
);
	import imfd_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	`IMFD_ASSERT_NOW(a_queue_no_overflow, push && !pop, !full, "push into full queue")
	`IMFD_ASSERT_NOW(a_queue_no_underflow, pop, head_valid, "pop from empty queue")
endmodule

FILE: rtl/imfd_back.sv
`timescale 1ns / 1ps
`include "interleaved_mono_framebuffer_draw_defines.svh"
module imfd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  imfd_pkg::cmd_t head,
	output logic           pop,
	output logic           clearing,
	imfd_rsp_if.source     rsp
);
	import imfd_pkg::*;

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_WR   = 2'd3;

	logic [7:0]        frame_store_q [STORE_DEPTH];
	logic [1:0]        state_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	cmd_t              cmd_q;
	logic [BYTE_W-1:0] b_q;
	logic [Y_W-1:0]    y_q;
	logic [ADDR_W-1:0] base_q;
	logic [7:0]        rdata_q;
	logic              out_valid_q;
	logic              out_pixel_q;

	logic              out_free;
	logic              row_done;
	logic              item_done;
	logic              wr_stall;
	logic              start_op;
	logic [7:0]        byte_mask;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] next_base;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              res_load;
	logic              res_pixel;

	assign clearing        = state_q == ST_CLR;
	assign out_free        = !out_valid_q || rsp.ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.pixel_value = out_pixel_q;

	always_comb begin
		row_done  = b_q == cmd_q.b_last;
		item_done = row_done && (y_q == cmd_q.y_last);
		wr_stall  = (state_q == ST_WR) && item_done && !out_free;
		// an empty request has nothing to do but report, so it waits for the result slot
		pop       = (state_q == ST_IDLE) && head_valid && ((head.op != OP_NOP) || out_free);
		start_op  = pop && (head.op != OP_NOP);
		byte_mask = ((b_q == cmd_q.b_first) ? cmd_q.m_first : 8'hff)
			& (row_done ? cmd_q.m_last : 8'hff);
		cur_addr  = base_q + ADDR_W'(b_q);
		next_base = (y_q[1:0] == 2'b11) ? base_q + WRAP_STEP : base_q + BANK_STEP;

		rd_en   = start_op || (state_q == ST_RD);
		rd_addr = start_op ? head.row_base + ADDR_W'(head.b_first) : cur_addr;

		mem_we  = clearing
			|| ((state_q == ST_WR) && !wr_stall && (cmd_q.op == OP_DRAW));
		wr_addr = clearing ? clr_cnt_q : cur_addr;
		wr_data = clearing ? 8'h00
			: (cmd_q.colour ? (rdata_q | byte_mask) : (rdata_q & ~byte_mask));

		res_load  = (pop && (head.op == OP_NOP))
			|| ((state_q == ST_WR) && item_done && out_free);
		res_pixel = (state_q == ST_WR) && (cmd_q.op == OP_READ)
			&& ((rdata_q & cmd_q.m_first) != 8'h00);
	end

	always_ff @(posedge clk) begin
		if (mem_we) frame_store_q[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= frame_store_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (start_op) begin
			cmd_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_cnt_q   <= '0;
			b_q         <= '0;
			y_q         <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
			out_pixel_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
				out_pixel_q <= res_pixel;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start_op) begin
						b_q     <= head.b_first;
						y_q     <= head.y_first;
						base_q  <= head.row_base;
						state_q <= ST_WR;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (!wr_stall) begin
						if (item_done) begin
							state_q <= ST_IDLE;
						end else if (row_done) begin
							y_q     <= y_q + Y_W'(1);
							b_q     <= cmd_q.b_first;
							base_q  <= next_base;
							state_q <= ST_RD;
						end else begin
							b_q     <= b_q + BYTE_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`IMFD_ASSERT_NOW(a_no_pop_in_clear, clearing, !pop, "request taken during clearing pass")
	`IMFD_ASSERT_NOW(a_read_never_writes, (state_q == ST_WR) && (cmd_q.op == OP_READ), !mem_we, "pixel read wrote the store")
	`IMFD_ASSERT_NEXT(a_start_goes_to_update, start_op, state_q == ST_WR, "started request skipped its update cycle")
endmodule

FILE: rtl/interleaved_mono_framebuffer_draw.sv
`timescale 1ns / 1ps
// channel  role     handshake            payload
// req      sink     req.valid/req.ready  mode, x_start, x_end, y_start, y_end, colour
// rsp      source   rsp.valid/rsp.ready  pixel_value
//
// a pixel draw or read is one store read and one update; a span or rectangle repeats both
// per byte touched, a read-modify-write through the single frame store read and write port.
// empty, clipped-away and unused requests skip the store and only load the result register.
// after reset a clearing pass zeroes the whole store with req.ready held low.
// a two-entry queue of decoded requests and a result register let either side stall alone.
module interleaved_mono_framebuffer_draw (
	input  logic       clk,
	input  logic       arst_n,
	imfd_req_if.sink   req,
	imfd_rsp_if.source rsp
);
	import imfd_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic full;
	logic head_valid;
	cmd_t head;
	logic pop;
	logic clearing;

	imfd_front u_front (
		.req      (req),
		.full     (full),
		.clearing (clearing),
		.push     (push),
		.cmd      (push_cmd)
	);

	imfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	imfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.rsp        (rsp)
	);
endmodule
